### rtl/cpnf_pkg.sv
// Shared types, constants and the keep rule for the contact pair neighbor filter.
`default_nettype none

package cpnf_pkg;

  localparam int DEF_MAX_PAIRS = 64;
  localparam int POS_W         = 12;
  localparam int SCORE_W       = 32;
  localparam int LIMIT_W       = 8;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;

  // 1000.0 in Q16.16
  localparam logic signed [SCORE_W-1:0] CUTOFF_RESET = 32'sd65536000;

  localparam logic [CFG_IDX_W-1:0] REG_SCORE_CUTOFF = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANK_LIMIT   = 1'd1;

  typedef struct packed {
    logic        [POS_W-1:0]   a;
    logic        [POS_W-1:0]   b;
    logic signed [SCORE_W-1:0] score;
  } pair_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SWEEP,
    ST_DRAIN,
    ST_COMMIT,
    ST_ORDER,
    ST_FETCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;       // store incoming pair
    logic start_run;  // clear sequencing counters
    logic sweep;      // issue compare read, advance j
    logic commit;     // write order entry for pair i
    logic emit_sel;   // port A addressed by order entry
    logic emit_load;  // load output register
    logic emit_next;  // advance emit rank
    logic finish;     // clear set for next run
  } cmd_t;

  typedef struct packed {
    logic j_last;
    logic i_last;
    logic r_last;
    logic keep;
    logic out_free;
  } status_t;

  // Keep rule: neighbor mark, reserved rank, or score above cutoff.
  function automatic logic keep_pair(input logic                      mark,
                                     input logic        [LIMIT_W-1:0] rank,
                                     input logic signed [SCORE_W-1:0] score,
                                     input logic signed [SCORE_W-1:0] cutoff,
                                     input logic        [LIMIT_W-1:0] limit);
    logic rank_ok;
    rank_ok = !limit[LIMIT_W-1] && (rank <= limit);
    return mark || rank_ok || (score > cutoff);
  endfunction

endpackage

`default_nettype wire

### rtl/contact_pair_neighbor_filter.sv
// Top level of the contact pair neighbor filter: controller plus datapath.
// Usage:
//   Input channel (in_valid/in_stall) carries one scored pair per transaction
//   (first_pos, second_pos, pair_score, is_last). While loading, in_stall is
//   low and one pair is taken every cycle. Pairs beyond MAX_PAIRS are dropped
//   and reported through overflow on every result of that run.
//   The transaction with is_last set closes the set. in_stall then stays high
//   while the set is ranked and filtered:
//     rank/mark pass: each stored pair is compared with every stored pair, one compare per
//     cycle against the pair store's second read port;
//     emit pass: per ranked pair an order read, a pair read and a decide,
//     the decide waiting on a kept pair while the receiver stalls.
//   Output channel (out_valid/out_stall) carries kept pairs in descending score
//   order (ties in arrival order); end_of_run marks the last one. A run with
//   no kept pair produces no transaction. One output register decouples the
//   sides; a stalled result holds and the emit pass waits on it.
//   Config writes (cfg_write_en, cfg_index, cfg_data) take effect next cycle
//   and are expected only while the block is idle.
//   Reset (rst, synchronous): empty set, cutoff 1000.0, rank limit 0.
`default_nettype none

module contact_pair_neighbor_filter #(
  parameter int MAX_PAIRS = cpnf_pkg::DEF_MAX_PAIRS
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_write_en,
  input  wire  [cpnf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [cpnf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [cpnf_pkg::POS_W-1:0]           first_pos,
  input  wire  [cpnf_pkg::POS_W-1:0]           second_pos,
  input  wire  signed [cpnf_pkg::SCORE_W-1:0]  pair_score,
  input  wire                                  is_last,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [cpnf_pkg::POS_W-1:0]           kept_first_pos,
  output logic [cpnf_pkg::POS_W-1:0]           kept_second_pos,
  output logic signed [cpnf_pkg::SCORE_W-1:0]  kept_score,
  output logic                                 end_of_run,
  output logic                                 overflow
);

  cpnf_pkg::cmd_t    cmd;
  cpnf_pkg::status_t status;

  // sequencing: load -> sweep/drain/commit per pair -> order/fetch/emit per rank
  cpnf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .is_last  (is_last),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // storage, rank and neighbor compare, keep decision, output register
  cpnf_dp #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .first_pos       (first_pos),
    .second_pos      (second_pos),
    .pair_score      (pair_score),
    .cmd             (cmd),
    .status          (status),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .kept_first_pos  (kept_first_pos),
    .kept_second_pos (kept_second_pos),
    .kept_score      (kept_score),
    .end_of_run      (end_of_run),
    .overflow        (overflow)
  );

endmodule

`default_nettype wire

### rtl/cpnf_ctrl.sv
// Controller state machine: load, rank sweep, commit and emit sequencing.
`default_nettype none

module cpnf_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  input  wire                       is_last,
  input  cpnf_pkg::status_t         status,
  output logic                      in_stall,
  output cpnf_pkg::cmd_t            cmd
);

  cpnf_pkg::state_t state;
  cpnf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpnf_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      cpnf_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid && is_last) begin
          cmd.start_run = 1'b1;
          state_next    = cpnf_pkg::ST_SWEEP;
        end
      end
      cpnf_pkg::ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.j_last) begin
          state_next = cpnf_pkg::ST_DRAIN;
        end
      end
      cpnf_pkg::ST_DRAIN: begin
        state_next = cpnf_pkg::ST_COMMIT;
      end
      cpnf_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = status.i_last ? cpnf_pkg::ST_ORDER : cpnf_pkg::ST_SWEEP;
      end
      cpnf_pkg::ST_ORDER: begin
        cmd.emit_sel = 1'b1;
        state_next   = cpnf_pkg::ST_FETCH;
      end
      cpnf_pkg::ST_FETCH: begin
        cmd.emit_sel = 1'b1;
        state_next   = cpnf_pkg::ST_EMIT;
      end
      cpnf_pkg::ST_EMIT: begin
        cmd.emit_sel = 1'b1;
        if (!status.keep || status.out_free) begin
          cmd.emit_load = status.keep;
          if (status.r_last) begin
            cmd.finish = 1'b1;
            state_next = cpnf_pkg::ST_LOAD;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = cpnf_pkg::ST_ORDER;
          end
        end
      end
      default: begin
        state_next = cpnf_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/cpnf_dp.sv
// Datapath: config registers, pair and order memories, rank/neighbor compare, output register.
`default_nettype none

module cpnf_dp #(
  parameter int MAX_PAIRS = cpnf_pkg::DEF_MAX_PAIRS
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      cfg_write_en,
  input  wire  [cpnf_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire  [cpnf_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  wire  [cpnf_pkg::POS_W-1:0]               first_pos,
  input  wire  [cpnf_pkg::POS_W-1:0]               second_pos,
  input  wire  signed [cpnf_pkg::SCORE_W-1:0]      pair_score,
  input  cpnf_pkg::cmd_t                           cmd,
  output cpnf_pkg::status_t                        status,
  input  wire                                      out_stall,
  output logic                                     out_valid,
  output logic [cpnf_pkg::POS_W-1:0]               kept_first_pos,
  output logic [cpnf_pkg::POS_W-1:0]               kept_second_pos,
  output logic signed [cpnf_pkg::SCORE_W-1:0]      kept_score,
  output logic                                     end_of_run,
  output logic                                     overflow
);

  localparam int IDX_W = $clog2(MAX_PAIRS);
  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int POS_W = cpnf_pkg::POS_W;

  logic signed [cpnf_pkg::SCORE_W-1:0] score_cutoff;
  logic        [cpnf_pkg::LIMIT_W-1:0] rank_limit;

  logic [CNT_W-1:0] count;
  logic             dropped;

  cpnf_pkg::pair_t  pair_mem [MAX_PAIRS];
  logic [IDX_W:0]   ord_mem  [MAX_PAIRS];
  cpnf_pkg::pair_t  pa;
  cpnf_pkg::pair_t  pb;
  logic [IDX_W:0]   ord_rd;
  logic [IDX_W-1:0] a_addr;

  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] j_d;
  logic [IDX_W-1:0] r;
  logic             cmp_valid;
  logic [IDX_W-1:0] rank_acc;
  logic             mark_acc;
  logic [CNT_W-1:0] kept_total;
  logic [CNT_W-1:0] emit_cnt;

  logic             store_en;
  logic             beat;
  logic             diag;
  logic             keep_commit;
  logic [POS_W:0]   ai1;
  logic [POS_W:0]   aj1;
  logic [POS_W:0]   bi1;
  logic [POS_W:0]   bj1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      score_cutoff <= cpnf_pkg::CUTOFF_RESET;
      rank_limit   <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        cpnf_pkg::REG_SCORE_CUTOFF: score_cutoff <= cfg_data;
        cpnf_pkg::REG_RANK_LIMIT:   rank_limit   <= cfg_data[cpnf_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign store_en = cmd.load && (count < CNT_W'(MAX_PAIRS));

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.finish) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (store_en) begin
        count <= count + CNT_W'(1);
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  assign a_addr = cmd.emit_sel ? ord_rd[IDX_W-1:0] : i;

  // pair store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (store_en) begin
      pair_mem[count[IDX_W-1:0]] <= '{a: first_pos, b: second_pos, score: pair_score};
    end
    pa <= pair_mem[a_addr];
    pb <= pair_mem[j];
  end

  // order store: rank -> {mark, index}
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ord_mem[rank_acc] <= {mark_acc, i};
    end
    ord_rd <= ord_mem[r];
  end

  // j outranks i: higher score, or equal score and earlier arrival
  assign beat = (pb.score > pa.score) || ((pb.score == pa.score) && (j_d < i));

  // diagonal neighbor, exact arithmetic (no wrap at the edges)
  assign ai1  = {1'b0, pa.a} + (POS_W+1)'(1);
  assign aj1  = {1'b0, pb.a} + (POS_W+1)'(1);
  assign bi1  = {1'b0, pa.b} + (POS_W+1)'(1);
  assign bj1  = {1'b0, pb.b} + (POS_W+1)'(1);
  assign diag = ((ai1 == {1'b0, pb.a}) && (bj1 == {1'b0, pa.b})) ||
                ((aj1 == {1'b0, pa.a}) && (bi1 == {1'b0, pb.b}));

  assign keep_commit = cpnf_pkg::keep_pair(mark_acc, cpnf_pkg::LIMIT_W'(rank_acc),
                                           pa.score, score_cutoff, rank_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      i          <= '0;
      j          <= '0;
      j_d        <= '0;
      r          <= '0;
      cmp_valid  <= 1'b0;
      rank_acc   <= '0;
      mark_acc   <= 1'b0;
      kept_total <= '0;
      emit_cnt   <= '0;
    end else begin
      cmp_valid <= cmd.sweep;
      j_d       <= j;
      if (cmd.start_run) begin
        i          <= '0;
        j          <= '0;
        r          <= '0;
        rank_acc   <= '0;
        mark_acc   <= 1'b0;
        kept_total <= '0;
        emit_cnt   <= '0;
      end else begin
        if (cmd.sweep) begin
          j <= j + IDX_W'(1);
        end
        if (cmp_valid) begin
          rank_acc <= rank_acc + (beat ? IDX_W'(1) : IDX_W'(0));
          mark_acc <= mark_acc | diag;
        end
        if (cmd.commit) begin
          i          <= i + IDX_W'(1);
          j          <= '0;
          rank_acc   <= '0;
          mark_acc   <= 1'b0;
          kept_total <= kept_total + (keep_commit ? CNT_W'(1) : CNT_W'(0));
        end
        if (cmd.emit_load) begin
          emit_cnt <= emit_cnt + CNT_W'(1);
        end
        if (cmd.emit_next) begin
          r <= r + IDX_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      kept_first_pos  <= pa.a;
      kept_second_pos <= pa.b;
      kept_score      <= pa.score;
      end_of_run      <= (emit_cnt + CNT_W'(1)) == kept_total;
      overflow        <= dropped;
    end
  end

  assign status.j_last   = CNT_W'(j) == (count - CNT_W'(1));
  assign status.i_last   = CNT_W'(i) == (count - CNT_W'(1));
  assign status.r_last   = CNT_W'(r) == (count - CNT_W'(1));
  assign status.keep     = cpnf_pkg::keep_pair(ord_rd[IDX_W], cpnf_pkg::LIMIT_W'(r),
                                               pa.score, score_cutoff, rank_limit);
  assign status.out_free = !out_valid || !out_stall;

`ifndef SYNTHESIS
  ap_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PAIRS))
    else $error("pair count above capacity");

  ap_sweep_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> (CNT_W'(j) < count))
    else $error("compare index beyond stored set");

  ap_rank_range: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (CNT_W'(rank_acc) < count))
    else $error("rank beyond stored set");

  ap_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

  ap_emit_count: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (emit_cnt < kept_total))
    else $error("more results than counted keeps");
`endif

endmodule

`default_nettype wire

### verif/pair_filter_checker.sv
// Checker for the contact pair neighbor filter: mirrors the registers, predicts kept pairs.
`timescale 1ns / 100ps

module pair_filter_checker #(
  parameter int MAX_PAIRS = cpnf_pkg::DEF_MAX_PAIRS
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_write_en,
  input  wire  [cpnf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [cpnf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire                                  in_valid,
  input  wire                                  in_stall,
  input  wire  [cpnf_pkg::POS_W-1:0]           first_pos,
  input  wire  [cpnf_pkg::POS_W-1:0]           second_pos,
  input  wire  signed [cpnf_pkg::SCORE_W-1:0]  pair_score,
  input  wire                                  is_last,
  input  wire                                  out_valid,
  input  wire                                  out_stall,
  input  wire  [cpnf_pkg::POS_W-1:0]           kept_first_pos,
  input  wire  [cpnf_pkg::POS_W-1:0]           kept_second_pos,
  input  wire  signed [cpnf_pkg::SCORE_W-1:0]  kept_score,
  input  wire                                  end_of_run,
  input  wire                                  overflow,
  output int                                   fail_count,
  output int                                   pending
);

  import cpnf_pkg::*;

  typedef struct packed {
    pair_t pair;
    logic  end_of_run;
    logic  overflow;
  } kept_t;

  logic signed [SCORE_W-1:0] cutoff_q;
  logic signed [LIMIT_W-1:0] rank_limit_q;
  pair_t                     loaded_pairs[$];
  logic                      pairs_dropped;
  kept_t                     kept_queue[$];
  int                        mismatches = 0;

  function automatic bit diagonal_pair(pair_t x, pair_t y);
    int xa, xb, ya, yb;
    xa = int'(x.a);
    xb = int'(x.b);
    ya = int'(y.a);
    yb = int'(y.b);
    return (xa + 1 == ya && xb - 1 == yb) || (xa - 1 == ya && xb + 1 == yb);
  endfunction

  // Rank the loaded set, mark diagonal neighbors, queue the pairs that pass.
  function automatic void rank_and_filter();
    int    order[$];
    bit    marked[MAX_PAIRS];
    kept_t run[$];
    kept_t item;
    int    k;
    for (int i = 0; i < loaded_pairs.size(); i++) begin
      // stable: goes behind every pair scoring at least as high
      k = 0;
      while (k < order.size() && loaded_pairs[order[k]].score >= loaded_pairs[i].score)
        k++;
      order.insert(k, i);
    end
    for (int i = 0; i < order.size(); i++)
      for (int j = i + 1; j < order.size(); j++)
        if (diagonal_pair(loaded_pairs[order[i]], loaded_pairs[order[j]])) begin
          marked[i] = 1'b1;
          marked[j] = 1'b1;
        end
    for (int r = 0; r < order.size(); r++)
      if (marked[r] || r <= int'(rank_limit_q) || loaded_pairs[order[r]].score > cutoff_q) begin
        item.pair       = loaded_pairs[order[r]];
        item.end_of_run = 1'b0;
        item.overflow   = pairs_dropped;
        run.insert(run.size(), item);
      end
    if (run.size() > 0)
      run[run.size()-1].end_of_run = 1'b1;
    foreach (run[i])
      kept_queue.insert(kept_queue.size(), run[i]);
    loaded_pairs.delete();
    pairs_dropped = 1'b0;
  endfunction

  task automatic report(input string msg);
    $display("%0t ns pair filter mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    kept_t want;
    pair_t got;
    if (rst) begin
      cutoff_q      = CUTOFF_RESET;
      rank_limit_q  = '0;
      pairs_dropped = 1'b0;
      loaded_pairs.delete();
      kept_queue.delete();
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == REG_SCORE_CUTOFF)
          cutoff_q = cfg_data;
        else if (cfg_index == REG_RANK_LIMIT)
          rank_limit_q = cfg_data[LIMIT_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (kept_queue.size() == 0) begin
          report($sformatf("unexpected result (%0d,%0d) score %0d",
                           kept_first_pos, kept_second_pos, kept_score));
        end else begin
          want = kept_queue.pop_front();
          if (kept_first_pos !== want.pair.a)
            report($sformatf("kept_first_pos %0d, want %0d", kept_first_pos, want.pair.a));
          if (kept_second_pos !== want.pair.b)
            report($sformatf("kept_second_pos %0d, want %0d", kept_second_pos, want.pair.b));
          if (kept_score !== want.pair.score)
            report($sformatf("kept_score %0d, want %0d", kept_score, want.pair.score));
          if (end_of_run !== want.end_of_run)
            report($sformatf("end_of_run %b, want %b", end_of_run, want.end_of_run));
          if (overflow !== want.overflow)
            report($sformatf("overflow %b, want %b", overflow, want.overflow));
        end
      end
      if (in_valid && !in_stall) begin
        got.a     = first_pos;
        got.b     = second_pos;
        got.score = pair_score;
        if (loaded_pairs.size() < MAX_PAIRS)
          loaded_pairs.insert(loaded_pairs.size(), got);
        else
          pairs_dropped = 1'b1;
        if (is_last)
          rank_and_filter();
      end
    end
    fail_count <= mismatches;
    pending    <= kept_queue.size();
  end

endmodule

### verif/tb.sv
// Testbench top for the contact pair neighbor filter: stimulus, pacing, watchdog, verdict.
`timescale 1ns / 100ps

module tb;

  import cpnf_pkg::*;

  localparam int MAXP         = DEF_MAX_PAIRS;
  localparam int RANDOM_ITEMS = 140;
  // Receiver hold-off long enough for a whole run to back up into the input.
  localparam int LONG_HOLD    = 400;
  // Worst quiet stretch is a full-set rank pass plus emit, followed by
  // the long hold-off; allow several times that.
  localparam int QUIET_LIMIT  = 20000;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index    = '0;
  logic [CFG_DATA_W-1:0]     cfg_data     = '0;
  logic                      in_valid     = 1'b0;
  logic                      in_stall;
  logic [POS_W-1:0]          first_pos    = '0;
  logic [POS_W-1:0]          second_pos   = '0;
  logic signed [SCORE_W-1:0] pair_score   = '0;
  logic                      is_last      = 1'b0;
  logic                      out_valid;
  logic                      out_stall    = 1'b0;
  logic [POS_W-1:0]          kept_first_pos;
  logic [POS_W-1:0]          kept_second_pos;
  logic signed [SCORE_W-1:0] kept_score;
  logic                      end_of_run;
  logic                      overflow;

  int fail_count;
  int pending;

  // Stimulus bookkeeping
  pair_t                     set_buf[$];
  int                        last_n      = 0;        // pairs stored by the latest set
  logic signed [SCORE_W-1:0] cur_cutoff  = CUTOFF_RESET;
  bit                        gaps_on     = 1'b1;
  int                        burst_left  = 0;
  bit                        long_hold   = 1'b0;     // request to the receiver
  int                        quiet       = 0;

  always #2 clk = ~clk;

  contact_pair_neighbor_filter #(.MAX_PAIRS(MAXP)) dut (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .first_pos, .second_pos, .pair_score, .is_last,
    .out_valid, .out_stall, .kept_first_pos, .kept_second_pos, .kept_score,
    .end_of_run, .overflow
  );

  pair_filter_checker #(.MAX_PAIRS(MAXP)) chk (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .first_pos, .second_pos, .pair_score, .is_last,
    .out_valid, .out_stall, .kept_first_pos, .kept_second_pos, .kept_score,
    .end_of_run, .overflow, .fail_count, .pending
  );

  // Watchdog: any accepted transaction on either side counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Receiver: rotating 16-bit stall pattern, re-drawn after a random span.
  // Some patterns are all zero, giving stretches with no back-pressure.
  initial begin : receiver
    logic [15:0] stall_bits;
    int          span;
    stall_bits = '0;
    span       = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        // long hold-off: the run backs up and the input stalls behind it
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (span == 0) begin
        span = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       stall_bits = '0;
          1:       stall_bits = 16'($urandom);
          2:       stall_bits = 16'($urandom & $urandom);
          default: stall_bits = 16'($urandom | $urandom);
        endcase
      end
      span--;
      out_stall <= stall_bits[0];
      stall_bits = {stall_bits[0], stall_bits[15:1]};
    end
  end

  // Rough cycles for the block to rank, mark and scan n stored pairs.
  function automatic int busy_cycles(input int n);
    return n * (n + 2) + 3 * n + 16;
  endfunction

  function automatic logic [POS_W-1:0] rim_pos();
    return $urandom_range(0, 1) ? POS_W'(4095 - $urandom_range(0, 1))
                                : POS_W'($urandom_range(0, 1));
  endfunction

  // Mix of full-range scores, values around the cutoff, and a small pool for ties.
  function automatic logic signed [SCORE_W-1:0] rand_score();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return cur_cutoff + $urandom_range(0, 2) - 1;
      3:       return int'($urandom_range(0, 4)) * 65536 - 2 * 65536;
      4:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return int'($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  task automatic add_pair(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b,
                          input logic signed [SCORE_W-1:0] score);
    pair_t p;
    p.a     = a;
    p.b     = b;
    p.score = score;
    set_buf.insert(set_buf.size(), p);
  endtask

  // Mostly diagonal chains hanging off earlier pairs, the rest scattered noise.
  task automatic build_random_set(input int n);
    pair_t p, anchor;
    set_buf.delete();
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 9) < 6) begin
        anchor = ($urandom_range(0, 3) == 0) ? set_buf[$urandom_range(0, i - 1)]
                                             : set_buf[i - 1];
        if ($urandom_range(0, 1)) begin
          p.a = anchor.a + 1'b1;
          p.b = anchor.b - 1'b1;
        end else begin
          p.a = anchor.a - 1'b1;
          p.b = anchor.b + 1'b1;
        end
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            p.a = POS_W'($urandom);
            p.b = POS_W'($urandom);
          end
          1: begin
            p.a = rim_pos();
            p.b = $urandom_range(0, 1) ? rim_pos() : POS_W'($urandom);
          end
          default: begin
            p.a = POS_W'(100 + $urandom_range(0, 6));
            p.b = POS_W'(100 + $urandom_range(0, 6));
          end
        endcase
      end
      p.score = rand_score();
      set_buf.insert(set_buf.size(), p);
    end
  endtask

  // Bursts of back-to-back transactions separated by short random gaps while gaps_on is set.
  task automatic pace();
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic offer_pair(input pair_t p, input bit last);
    in_valid   <= 1'b1;
    first_pos  <= p.a;
    second_pos <= p.b;
    pair_score <= p.score;
    is_last    <= last;
    do @(posedge clk); while (in_stall);
    pace();
  endtask

  task automatic send_set();
    foreach (set_buf[i])
      offer_pair(set_buf[i], i == set_buf.size() - 1);
    last_n = (set_buf.size() < MAXP) ? set_buf.size() : MAXP;
    set_buf.delete();
  endtask

  // Wait for every predicted result, then give a run that kept nothing
  // time to finish its scan before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (busy_cycles(last_n)) @(posedge clk);
  endtask

  // Both registers per call; upper data bits of the rank limit are don't-care.
  task automatic set_config(input logic signed [SCORE_W-1:0] cutoff,
                            input logic signed [LIMIT_W-1:0] limit);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_SCORE_CUTOFF;
    cfg_data     <= cutoff;
    @(posedge clk);
    cfg_index    <= REG_RANK_LIMIT;
    cfg_data     <= {24'($urandom), limit};
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_cutoff = cutoff;
  endtask

  initial begin : stimulus
    int                        ph, n, random_sent;
    logic signed [SCORE_W-1:0] c;
    logic signed [LIMIT_W-1:0] l;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, reset registers: cutoff 1000.0, rank limit 0
    // single pair at the field extremes
    add_pair(4095, 0, 32'sh7FFF_FFFF);
    send_set();
    // score equal to the cutoff is not above it; only the top rank survives
    add_pair(0, 0, 32'sh8000_0000);
    add_pair(4095, 4095, 0);
    add_pair(200, 300, CUTOFF_RESET);
    add_pair(500, 600, CUTOFF_RESET + 1);
    send_set();

    // --- neighbors only: nothing above the cutoff, no reserved ranks
    settle();
    set_config(32'sh7FFF_FFFF, -1);
    // positions at 0 and 4095 must not pair up through wrap-around;
    // equal scores come out in arrival order
    add_pair(0, 5, 7);
    add_pair(4095, 6, 7);
    add_pair(5, 4095, 7);
    add_pair(4, 0, 7);
    add_pair(0, 4095, 32'sh8000_0000);
    add_pair(1, 4094, -5);
    add_pair(2048, 2048, 7);
    add_pair(2049, 2047, 7);
    send_set();
    // lone pair with no neighbor: the run ends with no result at all
    add_pair(100, 100, 0);
    send_set();

    // --- keep every rank, including the most negative score
    settle();
    set_config(32'sh8000_0000, 64);
    add_pair(7, 7, -1);
    add_pair(8, 8, -1);
    add_pair(9, 9, -1);
    add_pair(10, 10, 32'sh8000_0000);
    send_set();

    // --- random phases, each with its own register setting
    random_sent = 0;
    for (ph = 0; random_sent < RANDOM_ITEMS; ph++) begin
      settle();
      case (ph % 6)
        0: begin
          c = rand_score();
          l = LIMIT_W'($urandom_range(0, 5));
        end
        1: begin
          c = 32'sh8000_0000;
          l = 64;
        end
        2: begin
          c = 32'sh7FFF_FFFF;
          l = -1;
        end
        3: begin
          c = CUTOFF_RESET;
          l = 0;
        end
        4: begin
          c = 0;
          l = LIMIT_W'($urandom_range(0, 65) - 1);
        end
        default: begin
          c = $urandom;
          l = LIMIT_W'($urandom_range(0, 65) - 1);
        end
      endcase
      set_config(c, l);
      gaps_on = (ph % 3) != 2;
      for (int s = 0; s < 4 && random_sent < RANDOM_ITEMS; s++) begin
        // one oversized set: fills the store, then drops two pairs,
        // the closing one among them
        n = (ph == 1 && s == 0) ? MAXP + 2 : $urandom_range(1, 8);
        // hold off while the small set just closed is being emitted
        if (ph == 1 && s == 2)
          long_hold = 1'b1;
        if (ph == 3 && s == 2)
          settle();
        build_random_set(n);
        random_sent += n;
        send_set();
      end
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

### sim.f
rtl/cpnf_pkg.sv
rtl/cpnf_ctrl.sv
rtl/cpnf_dp.sv
rtl/contact_pair_neighbor_filter.sv
verif/pair_filter_checker.sv
verif/tb.sv
